FILE: rtl/core/pgrc_pkg.sv
package pgrc_pkg;

	localparam int ADDR_W  = 40;
	localparam int REFC_W  = 8;
	localparam int MODE_W  = 2;
	localparam int STAT_W  = 2;
	localparam int CFG_W   = 40;
	localparam int CFG_IDX_W = 1;

	localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REF   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_DEREF = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_ADDR = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FLOW     = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_TOP  = 1'b1;

	localparam logic [REFC_W-1:0] REFC_ZERO = 8'd0;
	localparam logic [REFC_W-1:0] REFC_ONE  = 8'd1;
	localparam logic [REFC_W-1:0] REFC_MAX  = 8'hFF;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [ADDR_W-1:0] page_addr;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ADDR_W-1:0] result_addr;
		logic [REFC_W-1:0] count_after;
		logic              page_freed;
	} rsp_t;

endpackage

FILE: rtl/core/pgrc_ram.sv
module pgrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/pgrc_addr_chk.sv
module pgrc_addr_chk
	import pgrc_pkg::*;
#(
	parameter int NUM_PAGES  = 32768,
	parameter int PAGE_SHIFT = 12
) (
	input  logic [ADDR_W-1:0]            addr,
	input  logic [ADDR_W-1:0]            base,
	input  logic [ADDR_W-1:0]            top,
	output logic                         ok,
	output logic [$clog2(NUM_PAGES)-1:0] idx
);

	localparam int IDX_W = $clog2(NUM_PAGES);

	logic [ADDR_W-1:0] diff;
	logic [ADDR_W-1:0] off;
	logic              aligned;

	assign aligned = (addr[PAGE_SHIFT-1:0] == '0);
	assign diff    = addr - base;
	assign off     = diff >> PAGE_SHIFT;
	assign ok      = aligned && (addr >= base) && (addr < top) &&
	                 (off < ADDR_W'(NUM_PAGES));
	assign idx     = off[IDX_W-1:0];

endmodule

FILE: rtl/core/page_allocator_refcount_core.sv
// Channel  Direction  Handshake                 Payload
// req      in         req_valid / req_stall     req (mode, page_addr)
// rsp      out        rsp_valid / rsp_stall     rsp (status, result_addr, count_after, page_freed)
// cfg      in         cfg_we                    cfg_idx, cfg_data
//
// Each request is handled in ST_IDLE then ST_EXEC: the accept cycle checks the address and reads
// the free stack and count memories, and ST_EXEC commits the memory writes and loads the result.
// After reset a clearing pass zeroes the count memory with req stalled.
// A stalled result holds the request in ST_EXEC until the transfer completes.
module page_allocator_refcount_core
	import pgrc_pkg::*;
#(
	parameter int NUM_PAGES  = 32768,
	parameter int PAGE_SHIFT = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int IDX_W = $clog2(NUM_PAGES);
	localparam int CNT_W = $clog2(NUM_PAGES + 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic [IDX_W-1:0] clr_q;
	logic [CNT_W-1:0] free_cnt_q;
	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] top_q;

	logic [MODE_W-1:0] mode_s1;
	logic ok_s1;
	logic [IDX_W-1:0] idx_s1;

	rsp_t rsp_q;
	logic rsp_valid_q;

	logic accept;
	logic commit;
	logic chk_ok;
	logic [IDX_W-1:0] chk_idx;
	logic empty;
	logic full;

	logic stk_we;
	logic [IDX_W-1:0] stk_waddr;
	logic [IDX_W-1:0] stk_raddr;
	logic [IDX_W-1:0] stk_rdata;

	logic ref_we;
	logic [IDX_W-1:0] ref_waddr;
	logic [REFC_W-1:0] ref_wdata;
	logic [REFC_W-1:0] ref_rdata;

	logic do_we;
	logic [IDX_W-1:0] do_waddr;
	logic [REFC_W-1:0] do_wdata;
	logic do_push;
	logic do_pop;
	rsp_t rsp_n;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign commit    = (state_q == ST_EXEC) && (!rsp_valid_q || !rsp_stall);
	assign empty     = (free_cnt_q == '0);
	assign full      = (free_cnt_q == CNT_W'(NUM_PAGES));
	assign stk_raddr = IDX_W'(free_cnt_q - CNT_W'(1));
	assign stk_waddr = free_cnt_q[IDX_W-1:0];

	pgrc_addr_chk #(
		.NUM_PAGES  (NUM_PAGES),
		.PAGE_SHIFT (PAGE_SHIFT)
	) u_chk (
		.addr (req.page_addr),
		.base (base_q),
		.top  (top_q),
		.ok   (chk_ok),
		.idx  (chk_idx)
	);

	pgrc_ram #(
		.WIDTH (IDX_W),
		.DEPTH (NUM_PAGES)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (idx_s1),
		.re    (accept),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	pgrc_ram #(
		.WIDTH (REFC_W),
		.DEPTH (NUM_PAGES)
	) u_refc (
		.clk   (clk),
		.we    (ref_we),
		.waddr (ref_waddr),
		.wdata (ref_wdata),
		.re    (accept),
		.raddr (chk_idx),
		.rdata (ref_rdata)
	);

	always_comb begin
		do_we    = 1'b0;
		do_waddr = idx_s1;
		do_wdata = REFC_ZERO;
		do_push  = 1'b0;
		do_pop   = 1'b0;
		rsp_n    = '0;
		if (mode_s1 == MODE_ALLOC) begin
			if (empty) begin
				rsp_n.status = STAT_EMPTY;
			end else begin
				do_pop            = 1'b1;
				do_we             = 1'b1;
				do_waddr          = stk_rdata;
				do_wdata          = REFC_ONE;
				rsp_n.count_after = REFC_ONE;
				rsp_n.result_addr = base_q + (ADDR_W'(stk_rdata) << PAGE_SHIFT);
			end
		end else if (!ok_s1) begin
			rsp_n.status = STAT_BAD_ADDR;
		end else begin
			unique case (mode_s1)
				MODE_FREE: begin
					if (!full) begin
						do_push          = 1'b1;
						do_we            = 1'b1;
						rsp_n.page_freed = 1'b1;
					end else begin
						rsp_n.status      = STAT_FLOW;
						rsp_n.count_after = ref_rdata;
					end
				end
				MODE_REF: begin
					rsp_n.count_after = ref_rdata;
					if (ref_rdata == REFC_MAX) begin
						rsp_n.status = STAT_FLOW;
					end else begin
						do_we             = 1'b1;
						do_wdata          = ref_rdata + REFC_ONE;
						rsp_n.count_after = ref_rdata + REFC_ONE;
					end
				end
				MODE_DEREF: begin
					rsp_n.count_after = ref_rdata;
					if (ref_rdata == REFC_ZERO) begin
						rsp_n.status = STAT_FLOW;
					end else if (ref_rdata == REFC_ONE) begin
						if (!full) begin
							do_push           = 1'b1;
							do_we             = 1'b1;
							rsp_n.page_freed  = 1'b1;
							rsp_n.count_after = REFC_ZERO;
						end else begin
							rsp_n.status = STAT_FLOW;
						end
					end else begin
						do_we             = 1'b1;
						do_wdata          = ref_rdata - REFC_ONE;
						rsp_n.count_after = ref_rdata - REFC_ONE;
					end
				end
				default: begin
					rsp_n.status = STAT_EMPTY;
				end
			endcase
		end
	end

	assign stk_we    = commit && do_push;
	assign ref_we    = (state_q == ST_CLEAR) || (commit && do_we);
	assign ref_waddr = (state_q == ST_CLEAR) ? clr_q : do_waddr;
	assign ref_wdata = (state_q == ST_CLEAR) ? REFC_ZERO : do_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			top_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_POOL_BASE: base_q <= cfg_data[ADDR_W-1:0];
				REG_POOL_TOP:  top_q  <= cfg_data[ADDR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			free_cnt_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(NUM_PAGES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
			if (commit && do_push) begin
				free_cnt_q <= free_cnt_q + CNT_W'(1);
			end else if (commit && do_pop) begin
				free_cnt_q <= free_cnt_q - CNT_W'(1);
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= req.mode;
			ok_s1   <= chk_ok;
			idx_s1  <= chk_idx;
		end
		if (commit) begin
			rsp_q <= rsp_n;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
